### rtl/vmae_pkg.sv
// shared types, constants and codes for the video memory access engine
package vmae_pkg;

  localparam int WORD_AW      = 17;
  localparam int MEMORY_WORDS = 1 << WORD_AW;
  localparam int BYTE_AW      = WORD_AW + 2;
  localparam int COPY_WORDS   = 256;
  localparam int CNT_W        = (COPY_WORDS > 4) ? $clog2(COPY_WORDS) : 2;

  localparam logic [31:0] FILL_PATTERN = 32'h0f0f0f0f;

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_FILL  = 3'd1;
  localparam logic [2:0] OP_LATCH = 3'd2;
  localparam logic [2:0] OP_COPY  = 3'd3;
  localparam logic [2:0] OP_PIXEL = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [16:0] word_index;
    logic [31:0] write_data;
    logic [31:0] byte_mask;
    logic [8:0]  pixel_x;
    logic [3:0]  fine_scroll;
    logic [6:0]  palette_bank;
  } item_t;

  typedef struct packed {
    logic [14:0] pixel_pen;
    logic        unsupported_fill;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WR_MERGE,
    S_FILL,
    S_COPY_RD,
    S_COPY_WR,
    S_PIX
  } state_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_TARGET,
    RD_PIXEL,
    RD_COPY
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_MERGE,
    WR_FILL,
    WR_COPY
  } wr_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_BLANK,
    RES_PIXEL,
    RES_REFUSED
  } res_sel_t;

  typedef struct packed {
    logic     load_item;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     latch_src;
    logic     finish;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       fill_ok;
    logic       blank;
    logic       fill_last;
    logic       copy_last;
  } status_t;

endpackage

### rtl/vmae_ctrl.sv
// sequencing state machine for the video memory access engine
module vmae_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  vmae_pkg::status_t status,
  output vmae_pkg::cmd_t    cmd
);

  vmae_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vmae_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != vmae_pkg::S_IDLE);

  always_comb begin
    state_next    = state;
    cmd.load_item = 1'b0;
    cmd.rd_sel    = vmae_pkg::RD_NONE;
    cmd.wr_sel    = vmae_pkg::WR_NONE;
    cmd.cnt_clr   = 1'b0;
    cmd.cnt_inc   = 1'b0;
    cmd.latch_src = 1'b0;
    cmd.finish    = 1'b0;
    cmd.res_sel   = vmae_pkg::RES_ZERO;
    unique case (state)
      vmae_pkg::S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          state_next    = vmae_pkg::S_DECODE;
        end
      end
      vmae_pkg::S_DECODE: begin
        unique case (status.op)
          vmae_pkg::OP_WRITE: begin
            cmd.rd_sel = vmae_pkg::RD_TARGET;
            state_next = vmae_pkg::S_WR_MERGE;
          end
          vmae_pkg::OP_FILL: begin
            if (status.fill_ok) begin
              cmd.cnt_clr = 1'b1;
              state_next  = vmae_pkg::S_FILL;
            end else begin
              cmd.finish  = 1'b1;
              cmd.res_sel = vmae_pkg::RES_REFUSED;
              state_next  = vmae_pkg::S_IDLE;
            end
          end
          vmae_pkg::OP_LATCH: begin
            cmd.latch_src = 1'b1;
            cmd.finish    = 1'b1;
            state_next    = vmae_pkg::S_IDLE;
          end
          vmae_pkg::OP_COPY: begin
            cmd.cnt_clr = 1'b1;
            state_next  = vmae_pkg::S_COPY_RD;
          end
          vmae_pkg::OP_PIXEL: begin
            if (status.blank) begin
              cmd.finish  = 1'b1;
              cmd.res_sel = vmae_pkg::RES_BLANK;
              state_next  = vmae_pkg::S_IDLE;
            end else begin
              cmd.rd_sel = vmae_pkg::RD_PIXEL;
              state_next = vmae_pkg::S_PIX;
            end
          end
          default: begin
            // spare opcodes write nothing to the ram and finish with a zero result
            cmd.finish = 1'b1;
            state_next = vmae_pkg::S_IDLE;
          end
        endcase
      end
      vmae_pkg::S_WR_MERGE: begin
        cmd.wr_sel = vmae_pkg::WR_MERGE;
        cmd.finish = 1'b1;
        state_next = vmae_pkg::S_IDLE;
      end
      vmae_pkg::S_FILL: begin
        cmd.wr_sel  = vmae_pkg::WR_FILL;
        cmd.cnt_inc = 1'b1;
        if (status.fill_last) begin
          cmd.finish = 1'b1;
          state_next = vmae_pkg::S_IDLE;
        end
      end
      vmae_pkg::S_COPY_RD: begin
        cmd.rd_sel = vmae_pkg::RD_COPY;
        state_next = vmae_pkg::S_COPY_WR;
      end
      vmae_pkg::S_COPY_WR: begin
        cmd.wr_sel  = vmae_pkg::WR_COPY;
        cmd.cnt_inc = 1'b1;
        if (status.copy_last) begin
          cmd.finish = 1'b1;
          state_next = vmae_pkg::S_IDLE;
        end else begin
          state_next = vmae_pkg::S_COPY_RD;
        end
      end
      vmae_pkg::S_PIX: begin
        cmd.finish  = 1'b1;
        cmd.res_sel = vmae_pkg::RES_PIXEL;
        state_next  = vmae_pkg::S_IDLE;
      end
      default: begin
        state_next = vmae_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/vmae_datapath.sv
// video ram, address generation, merge logic and result register
module vmae_datapath (
  input  logic              clk,
  input  logic              rst,
  input  vmae_pkg::item_t   item,
  input  logic              cfg_valid,
  input  logic [31:0]       cfg_data,
  input  vmae_pkg::cmd_t    cmd,
  output vmae_pkg::status_t status,
  output vmae_pkg::result_t result,
  output logic              result_valid
);

  logic [31:0] mem [vmae_pkg::MEMORY_WORDS];

  vmae_pkg::item_t               cur;
  logic [vmae_pkg::BYTE_AW-1:0]  src_addr;
  logic [31:0]                   fill_value;
  logic [vmae_pkg::CNT_W-1:0]    cnt;
  logic [1:0]                    pix_lane;
  logic [31:0]                   rd_data;

  logic [vmae_pkg::BYTE_AW-1:0]  pix_addr;
  logic [vmae_pkg::WORD_AW-1:0]  copy_src;
  logic [vmae_pkg::WORD_AW-1:0]  copy_dst;
  logic [vmae_pkg::WORD_AW-1:0]  rd_addr;
  logic [vmae_pkg::WORD_AW-1:0]  wr_addr;
  logic [31:0]                   wr_data;
  logic [31:0]                   merge_mask;
  logic                          rd_en;
  logic                          wr_en;
  vmae_pkg::result_t             res_next;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cur <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_addr   <= '0;
      fill_value <= '0;
    end else begin
      if (cmd.latch_src) begin
        src_addr <= {cur.word_index, 2'b00};
      end
      if (cfg_valid) begin
        fill_value <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  // scan address wraps at the byte size of the ram
  assign pix_addr = src_addr + vmae_pkg::BYTE_AW'(cur.fine_scroll[1:0])
                  + vmae_pkg::BYTE_AW'(cur.pixel_x);
  assign copy_src = src_addr[vmae_pkg::BYTE_AW-1:2] + vmae_pkg::WORD_AW'(cnt);
  assign copy_dst = cur.word_index + vmae_pkg::WORD_AW'(cnt);

  always_ff @(posedge clk) begin
    if (cmd.rd_sel == vmae_pkg::RD_PIXEL) begin
      pix_lane <= pix_addr[1:0];
    end
  end

  // zero data bytes drop out of the write mask
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      merge_mask[i*8 +: 8] = (cur.write_data[i*8 +: 8] != 8'h00) ?
                             cur.byte_mask[i*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = cur.word_index;
    unique case (cmd.rd_sel)
      vmae_pkg::RD_NONE:   rd_en   = 1'b0;
      vmae_pkg::RD_TARGET: rd_addr = cur.word_index;
      vmae_pkg::RD_PIXEL:  rd_addr = pix_addr[vmae_pkg::BYTE_AW-1:2];
      vmae_pkg::RD_COPY:   rd_addr = copy_src;
      default:             rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = cur.word_index;
    wr_data = (rd_data & ~merge_mask) | (cur.write_data & merge_mask);
    unique case (cmd.wr_sel)
      vmae_pkg::WR_NONE:  wr_en = 1'b0;
      vmae_pkg::WR_MERGE: wr_addr = cur.word_index;
      vmae_pkg::WR_FILL: begin
        wr_addr = {cur.word_index[vmae_pkg::WORD_AW-1:2], cnt[1:0]};
        wr_data = fill_value;
      end
      vmae_pkg::WR_COPY: begin
        wr_addr = copy_dst;
        wr_data = rd_data;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign status.op        = cur.opcode;
  assign status.fill_ok   = ((cur.write_data & cur.byte_mask & vmae_pkg::FILL_PATTERN)
                             == vmae_pkg::FILL_PATTERN);
  assign status.blank     = cur.fine_scroll[3];
  assign status.fill_last = (cnt[1:0] == 2'b11);
  assign status.copy_last = (cnt == vmae_pkg::CNT_W'(vmae_pkg::COPY_WORDS - 1));

  always_comb begin
    res_next = '0;
    unique case (cmd.res_sel)
      vmae_pkg::RES_ZERO:    res_next = '0;
      vmae_pkg::RES_BLANK:   res_next.pixel_pen = {cur.palette_bank, 8'h00};
      vmae_pkg::RES_PIXEL:   res_next.pixel_pen = {cur.palette_bank,
                                                   rd_data[pix_lane*8 +: 8]};
      vmae_pkg::RES_REFUSED: res_next.unsupported_fill = 1'b1;
      default:               res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish;
    end
  end

endmodule

### rtl/video_memory_access_engine_top.sv
// top level of the video memory access engine
//
//  channel   signals                         direction  transfer
//  command   start, busy, item               in         start && !busy
//  result    result_valid, result            out        one-cycle strobe
//  config    cfg_valid, cfg_ready, cfg_data  in         cfg_valid && cfg_ready
//
// latch, spare, refused or blanked items finish from decode; write items read
// and then write the target word (read-modify-write), pixel reads read one word;
// bulk fill writes four words, copy moves 256 (one read and then one write per word)
// result strobe in the cycle after the item completes, busy already low, so the
// next word can be taken in that cycle
// synchronous reset clears sequencer, source latch and fill value, not the ram;
// results cannot be stalled
module video_memory_access_engine_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  vmae_pkg::item_t   item,
  output logic              result_valid,
  output vmae_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  vmae_pkg::cmd_t    cmd;
  vmae_pkg::status_t status;

  assign cfg_ready = 1'b1;

  vmae_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  vmae_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

### rtl/vmae_checker.sv
// port-level checks for the video memory access engine
module vmae_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input vmae_pkg::result_t result
);

  // an accepted word keeps the engine busy for at least the decode cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepting a word");

  // the strobe arrives only once the sequencer is back at rest
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result strobe while busy");

  // every item passes through decode before it finishes, so strobes never touch
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  // a refused fill never carries a pen
  a_refused_no_pen: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.unsupported_fill) |-> (result.pixel_pen == 15'd0))
    else $error("refused fill with nonzero pen");

endmodule

bind video_memory_access_engine_top vmae_checker u_vmae_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
